// ----- design/dq_pkg.sv -----
package dq_pkg;

  localparam int WORD_W = 32;
  localparam int OCC_W  = 5;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  localparam logic [WORD_W-1:0] NONE_VALUE = '1;

  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
    logic pop_back;
  } cell_ctrl_t;

endpackage

// ----- design/dq_cell.sv -----
module dq_cell
  import dq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cell_ctrl_t        ctrl,
  input  logic [WORD_W-1:0] push_value,
  input  logic [WORD_W-1:0] left_data,
  input  logic              left_occ,
  input  logic [WORD_W-1:0] right_data,
  input  logic              right_occ,
  output logic [WORD_W-1:0] data,
  output logic              occ,
  output logic              last
);

  logic [WORD_W-1:0] data_next;
  logic              occ_next;

  assign last = occ && !right_occ;

  always_comb begin
    data_next = data;
    occ_next  = occ;
    if (ctrl.push_front) begin
      data_next = left_data;
      occ_next  = left_occ;
    end else if (ctrl.pop_front) begin
      data_next = right_data;
      occ_next  = right_occ;
    end else if (ctrl.push_back) begin
      if (!occ && left_occ) begin
        data_next = push_value;
        occ_next  = 1'b1;
      end
    end else if (ctrl.pop_back) begin
      if (last) begin
        occ_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
    if (rst) begin
      occ <= 1'b0;
    end else begin
      occ <= occ_next;
    end
  end

endmodule

// ----- design/double_ended_queue.sv -----
// channel  | handshake          | payload
// ---------+--------------------+-------------------------------
// in       | in_valid, in_stall | opcode, push_value
// out      | out_valid,out_stall| pop_value, status, occupancy
//
// One item per cycle while not stalled; result is registered on accept.
// Entries live in a row of cells, front at cell 0; a front push or pop
// moves the row at once, a back op one cell; no item waits on another.
// Reset (synchronous) empties the row and clears out_valid.
// in_stall is raised only while a result waits under out_stall.
module double_ended_queue
  import dq_pkg::*;
#(
  parameter int DEPTH = 16
)
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        opcode,
  input  logic signed [WORD_W-1:0] push_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [WORD_W-1:0] pop_value,
  output logic [1:0]        status,
  output logic [OCC_W-1:0]  occupancy
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [WORD_W-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]  cell_occ;
  logic [DEPTH-1:0]  cell_last;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic              accept;
  logic              full;
  logic              empty;
  op_t               op;
  cell_ctrl_t        ctrl;
  logic [WORD_W-1:0] back_value;
  logic [WORD_W-1:0] res_value;
  status_t           res_status;
  logic [CW+OCC_W-1:0] count_ext;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = cell_occ[DEPTH-1];
  assign empty    = !cell_occ[0];
  assign op       = op_t'(opcode);

  always_comb begin
    ctrl       = '0;
    res_value  = NONE_VALUE;
    res_status = ST_DONE;
    count_next = count;
    unique case (op) inside
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (full) begin
          res_status = ST_FULL;
        end else begin
          ctrl.push_front = accept && (op == OP_PUSH_FRONT);
          ctrl.push_back  = accept && (op == OP_PUSH_BACK);
          count_next      = count + CW'(1);
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (empty) begin
          res_status = ST_EMPTY;
        end else begin
          ctrl.pop_front = accept && (op == OP_POP_FRONT);
          ctrl.pop_back  = accept && (op == OP_POP_BACK);
          res_value      = (op == OP_POP_FRONT) ? cell_data[0] : back_value;
          count_next     = count - CW'(1);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    back_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_value = back_value | (cell_data[i] & {WORD_W{cell_last[i]}});
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WORD_W-1:0] l_data;
    logic              l_occ;
    logic [WORD_W-1:0] r_data;
    logic              r_occ;

    if (g == 0) begin : g_first
      assign l_data = push_value;
      assign l_occ  = 1'b1;
    end else begin : g_mid
      assign l_data = cell_data[g-1];
      assign l_occ  = cell_occ[g-1];
    end

    if (g == DEPTH - 1) begin : g_end
      assign r_data = '0;
      assign r_occ  = 1'b0;
    end else begin : g_inner
      assign r_data = cell_data[g+1];
      assign r_occ  = cell_occ[g+1];
    end

    dq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .push_value (push_value),
      .left_data  (l_data),
      .left_occ   (l_occ),
      .right_data (r_data),
      .right_occ  (r_occ),
      .data       (cell_data[g]),
      .occ        (cell_occ[g]),
      .last       (cell_last[g])
    );
  end

  assign count_ext = {{OCC_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      count     <= '0;
    end else begin
      if (accept) begin
        out_valid <= 1'b1;
        count     <= count_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (accept) begin
      pop_value <= res_value;
      status    <= res_status;
      occupancy <= count_ext[OCC_W-1:0];
    end
  end

endmodule
